/* design/decaying_ring_slot_store_defines.svh */
// Assertion macros for the decaying ring slot store.
// Used by the top level only; needs a clk and rst in scope.
`ifndef DECAYING_RING_SLOT_STORE_DEFINES_SVH
`define DECAYING_RING_SLOT_STORE_DEFINES_SVH

// same-cycle implication
`define DRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/drs_pkg.sv */
// Package for the decaying ring slot store: payload types, register codes,
// and the fractional power-of-two table built at elaboration. No dependencies.
package drs_pkg;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        new_alpha;
    logic [31:0]        new_age;
    logic signed [31:0] new_pos_y;
    logic signed [15:0] new_drift_y;
    logic [15:0]        step_time;
    logic [63:0]        frame_number;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  slot_written;
    logic [6:0]  live_entries;
    logic [31:0] evictions;
    logic [31:0] inserts;
    logic [63:0] last_frame;
  } out_item_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [31:0] age;
    logic [31:0] pos_y;
    logic [15:0] drift_y;
  } entry_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESHOLD     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALVINGS_PER_SECOND = 1'd1;

  // 0.02 in Q0.16
  localparam logic [10:0] DRIFT_SCALE = 11'd1311;

  typedef logic [16:0] pow_tab_t [256];

  function automatic logic [63:0] root_nearest(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    logic [63:0] x;
    r    = '0;
    bitv = 64'd1 << 62;
    x    = v;
    for (int i = 0; i < 32; i++) begin
      if (bitv > x) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (x >= r + bitv) begin
          x = x - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    if (x > r) r = r + 64'd1;
    return r;
  endfunction

  // round(65536 * 2^(-f/256)) via a chain of rounded Q32 roots of 1/2
  function automatic pow_tab_t build_pow_tab();
    pow_tab_t    tab;
    logic [63:0] root [8];
    logic [63:0] s;
    logic [63:0] p;
    s = 64'd1 << 31;
    for (int k = 0; k < 8; k++) begin
      s = root_nearest(s << 32);
      root[k] = s;
    end
    for (int f = 0; f < 256; f++) begin
      p = 64'd1 << 32;
      for (int k = 0; k < 8; k++) begin
        if (((f >> (7 - k)) & 1) != 0) p = (p * root[k] + (64'd1 << 31)) >> 32;
      end
      tab[f] = 17'((p + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

/* design/decaying_ring_slot_store.sv */
// Decaying ring slot store top level: entry memory, insert path and tick walk.
// Depends on drs_pkg and decaying_ring_slot_store_defines.svh.
//
// One transaction at a time. An insert goes through a memory read, a
// read-modify-write and an output load. A tick with zero step goes straight
// to the output load. A tick with a nonzero step walks the whole ring: the entry
// memory has one read and one write port, so the walk reads one slot per cycle
// through a 3-stage decay/drift pipeline and writes each live slot back.
// No clearing pass after reset: slots above the fill mark read as empty.
// A result waits in the output register until taken; the next transaction is
// accepted meanwhile.
`include "decaying_ring_slot_store_defines.svh"

module decaying_ring_slot_store #(
  parameter int RING_SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  drs_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output drs_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [drs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [drs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CNT_W = $clog2(RING_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(RING_SLOTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INS   = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_PREP2 = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]        state;
  logic [15:0]       alpha_threshold;
  logic [23:0]       halvings_per_second;
  logic [IDX_W-1:0]  write_index;
  logic [CNT_W-1:0]  filled;
  logic [CNT_W-1:0]  live_total;
  logic [31:0]       evict_total;
  logic [31:0]       insert_total;
  logic [63:0]       frame_seen;
  logic [IDX_W-1:0]  slot_reg;
  drs_pkg::in_item_t item;

  logic [15:0]       x_reg;
  logic [26:0]       dt_scaled;
  logic [16:0]       pow_reg;
  logic [CNT_W-1:0]  rd_cnt;

  drs_pkg::entry_t   mem [RING_SLOTS];
  drs_pkg::entry_t   mem_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;
  drs_pkg::entry_t   wr_data;

  logic              in_acc;
  logic              issue;
  logic              out_free;

  // walk pipeline
  logic              v1, v2, v3;
  logic              in1;
  logic [IDX_W-1:0]  idx1, idx2, idx3;
  logic [32:0]       prod2;
  logic [42:0]       mag2;
  logic [31:0]       age2, age3;
  logic [31:0]       pos2, pos3;
  logic [15:0]       drift2, drift3;
  logic [15:0]       a3;
  logic [58:0]       mag3;

  logic              live1;
  logic [15:0]       drift_abs1;
  logic [32:0]       age_sum1;
  logic [15:0]       a2;
  logic [7:0]        n2;
  logic [16:0]       prod_hi2;
  logic [18:0]       delta3;
  logic signed [33:0] pos_sum3;
  logic [31:0]       pos_sat3;
  logic              dies3;
  logic              ins_live;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign issue    = (state == ST_WALK) && (rd_cnt < SLOTS_C);
  assign rd_addr  = (state == ST_IDLE) ? write_index : rd_cnt[IDX_W-1:0];

  // insert: slot counts as live only if written since reset and above threshold
  assign ins_live = (CNT_W'(slot_reg) < filled) &&
                    (mem_q.alpha > alpha_threshold);

  // stage 1 combinational
  assign live1      = in1 && (mem_q.alpha > alpha_threshold);
  assign drift_abs1 = mem_q.drift_y[15] ? 16'(-mem_q.drift_y) : mem_q.drift_y;
  assign age_sum1   = {1'b0, mem_q.age} + {17'd0, item.step_time};

  // stage 2 combinational: alpha' = prod >> (16 + n)
  assign n2       = x_reg[15:8];
  assign prod_hi2 = prod2[32:16];
  assign a2       = (n2 > 8'd16) ? 16'd0 : 16'(prod_hi2 >> n2[4:0]);

  // stage 3 combinational
  assign delta3   = mag3[58:40];
  assign pos_sum3 = drift3[15] ? (34'(signed'(pos3)) - 34'(signed'({1'b0, delta3})))
                               : (34'(signed'(pos3)) + 34'(signed'({1'b0, delta3})));
  assign pos_sat3 = (pos_sum3 > 34'sd2147483647)  ? 32'h7FFF_FFFF :
                    (pos_sum3 < -34'sd2147483648) ? 32'h8000_0000 : pos_sum3[31:0];
  assign dies3    = (a3 <= alpha_threshold);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = slot_reg;
    wr_data = {item.new_alpha, item.new_age, item.new_pos_y, item.new_drift_y};
    if (state == ST_INS) begin
      mem_we = 1'b1;
    end else if (v3) begin
      mem_we  = 1'b1;
      wr_addr = idx3;
      wr_data = {(dies3 ? 16'd0 : a3), age3, pos_sat3, drift3};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) item <= in_data;
    if (state == ST_PREP) begin
      x_reg     <= 16'((40'(item.step_time) * 40'(halvings_per_second)) >> 24);
      dt_scaled <= 27'(item.step_time) * 27'(drs_pkg::DRIFT_SCALE);
    end
    if (state == ST_PREP2) pow_reg <= drs_pkg::POW_TAB[x_reg[7:0]];
    idx1   <= rd_addr;
    in1    <= (CNT_W'(rd_addr) < filled);
    idx2   <= idx1;
    prod2  <= 33'(mem_q.alpha) * 33'(pow_reg);
    mag2   <= 43'(drift_abs1) * 43'(dt_scaled);
    age2   <= age_sum1[32] ? 32'hFFFF_FFFF : age_sum1[31:0];
    pos2   <= mem_q.pos_y;
    drift2 <= mem_q.drift_y;
    idx3   <= idx2;
    a3     <= a2;
    mag3   <= 59'(mag2) * 59'(a2);
    age3   <= age2;
    pos3   <= pos2;
    drift3 <= drift2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      alpha_threshold     <= 16'd1;
      halvings_per_second <= 24'd65536;
      write_index         <= '0;
      filled              <= '0;
      live_total          <= '0;
      evict_total         <= '0;
      insert_total        <= '0;
      frame_seen          <= '0;
      slot_reg            <= '0;
      rd_cnt              <= '0;
      v1                  <= 1'b0;
      v2                  <= 1'b0;
      v3                  <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          drs_pkg::REG_ALPHA_THRESHOLD:     alpha_threshold <= cfg_data[15:0];
          drs_pkg::REG_HALVINGS_PER_SECOND: halvings_per_second <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_EMIT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      v1 <= issue;
      v2 <= v1 && live1;
      v3 <= v2;
      if (issue) rd_cnt <= rd_cnt + 1'b1;
      if (v3 && dies3 && live_total != '0) live_total <= live_total - 1'b1;

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.cmd == drs_pkg::CMD_INSERT) begin
              slot_reg <= write_index;
              state    <= ST_INS;
            end else begin
              frame_seen <= in_data.frame_number;
              slot_reg   <= '0;
              state      <= (in_data.step_time == 16'd0) ? ST_EMIT : ST_PREP;
            end
          end
        end
        ST_INS: begin
          if (ins_live) evict_total <= evict_total + 32'd1;
          else if (live_total < SLOTS_C) live_total <= live_total + 1'b1;
          if (CNT_W'(slot_reg) == filled) filled <= filled + 1'b1;
          write_index  <= (CNT_W'(slot_reg) == SLOTS_C - 1'b1) ? '0 : slot_reg + 1'b1;
          insert_total <= insert_total + 32'd1;
          state        <= ST_EMIT;
        end
        ST_PREP:  state <= ST_PREP2;
        ST_PREP2: begin
          rd_cnt <= '0;
          state  <= ST_WALK;
        end
        ST_WALK: begin
          if (!issue && !v1 && !v2 && !v3) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic [IDX_W+5:0] slot_ext;
  logic [CNT_W+6:0] live_ext;
  assign slot_ext = {6'd0, slot_reg};
  assign live_ext = {7'd0, live_total};

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_data.slot_written <= slot_ext[5:0];
      out_data.live_entries <= live_ext[6:0];
      out_data.evictions    <= evict_total;
      out_data.inserts      <= insert_total;
      out_data.last_frame   <= frame_seen;
    end
  end

  `DRS_ASSERT_NOW(a_live_bound, 1'b1, live_total <= SLOTS_C, "live count above ring size")
  `DRS_ASSERT_NOW(a_fill_bound, 1'b1, filled <= SLOTS_C, "fill mark above ring size")
  `DRS_ASSERT_NEXT(a_accept_busy, in_acc, state != ST_IDLE, "accept did not start work")
  `DRS_ASSERT_NOW(a_wb_in_walk, v3, state == ST_WALK, "tick write-back outside walk")

endmodule
